[rtl/core/sll_pkg.sv]
// ----------------------------------------------------------------------------
// sll_pkg - shared types and codes of the statement language lexer
// Character classes, queue item and result layouts, token/operator/error codes.
// ----------------------------------------------------------------------------
package sll_pkg;

  // Character classes produced by the front end
  typedef enum logic [4:0] {
    CC_SPACE  = 5'd0,
    CC_DIGIT  = 5'd1,
    CC_ALPHA  = 5'd2,
    CC_BANG   = 5'd3,
    CC_EQ     = 5'd4,
    CC_LT     = 5'd5,
    CC_GT     = 5'd6,
    CC_AMP    = 5'd7,
    CC_PIPE   = 5'd8,
    CC_PLUS   = 5'd9,
    CC_MINUS  = 5'd10,
    CC_STAR   = 5'd11,
    CC_SLASH  = 5'd12,
    CC_PCT    = 5'd13,
    CC_LBRACE = 5'd14,
    CC_RBRACE = 5'd15,
    CC_LPAREN = 5'd16,
    CC_RPAREN = 5'd17,
    CC_SEMI   = 5'd18,
    CC_BAD    = 5'd19
  } char_class_t;

  // Classified byte handed from front to back
  typedef struct packed {
    logic        end_mark;
    logic        is_zero;
    char_class_t cls;
  } lex_item_t;

  // One token result
  typedef struct packed {
    logic [3:0]  kind;
    logic [3:0]  op;
    logic        lor;
    logic [15:0] start;
    logic [15:0] len;
    logic [1:0]  err;
    logic        last;
  } result_t;

  // Token kinds
  localparam logic [3:0] KIND_INT    = 4'd0;
  localparam logic [3:0] KIND_NAME   = 4'd1;
  localparam logic [3:0] KIND_NOT    = 4'd2;
  localparam logic [3:0] KIND_ASSIGN = 4'd3;
  localparam logic [3:0] KIND_REL    = 4'd4;
  localparam logic [3:0] KIND_ADD    = 4'd5;
  localparam logic [3:0] KIND_MUL    = 4'd6;
  localparam logic [3:0] KIND_LOGIC  = 4'd7;
  localparam logic [3:0] KIND_LBRACE = 4'd8;
  localparam logic [3:0] KIND_RBRACE = 4'd9;
  localparam logic [3:0] KIND_LPAREN = 4'd10;
  localparam logic [3:0] KIND_RPAREN = 4'd11;
  localparam logic [3:0] KIND_SEMI   = 4'd12;
  localparam logic [3:0] KIND_EOF    = 4'd13;
  localparam logic [3:0] KIND_ERROR  = 4'd14;

  // Operator codes
  localparam logic [3:0] OP_NONE  = 4'd0;
  localparam logic [3:0] OP_NE    = 4'd1;
  localparam logic [3:0] OP_EQEQ  = 4'd2;
  localparam logic [3:0] OP_LT    = 4'd3;
  localparam logic [3:0] OP_GT    = 4'd4;
  localparam logic [3:0] OP_LE    = 4'd5;
  localparam logic [3:0] OP_GE    = 4'd6;
  localparam logic [3:0] OP_PLUS  = 4'd7;
  localparam logic [3:0] OP_MINUS = 4'd8;
  localparam logic [3:0] OP_STAR  = 4'd9;
  localparam logic [3:0] OP_SLASH = 4'd10;
  localparam logic [3:0] OP_PCT   = 4'd11;
  localparam logic [3:0] OP_LOGIC = 4'd12;

  // Error codes
  localparam logic [1:0] ERR_NONE  = 2'd0;
  localparam logic [1:0] ERR_INT   = 2'd1;
  localparam logic [1:0] ERR_LOGIC = 2'd2;
  localparam logic [1:0] ERR_CHAR  = 2'd3;

endpackage

[rtl/core/sll_fifo.sv]
// ----------------------------------------------------------------------------
// sll_fifo - small synchronous queue
// Register-based FIFO, one push and one pop per cycle, power-of-two depth.
// ----------------------------------------------------------------------------
module sll_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] pop_data,
  output logic             empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr;
  logic [AW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == CW'(DEPTH));
  assign empty    = (count == '0);
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;
  assign pop_data = mem[rd_ptr];

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  // pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + AW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + AW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + CW'(1);
      end else if (do_pop && !do_push) begin
        count <= count - CW'(1);
      end
    end
  end

endmodule

[rtl/core/sll_front.sv]
// ----------------------------------------------------------------------------
// sll_front - byte intake and character classification
// Classifies each accepted byte and queues it for the lexing engine.
// ----------------------------------------------------------------------------
module sll_front
  import sll_pkg::*;
#(
  parameter int DEPTH = 2
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  logic [7:0] in_char,
  input  logic      in_end,
  output logic      item_valid,
  input  logic      item_pop,
  output lex_item_t item
);

  char_class_t cls;
  lex_item_t   item_in;
  logic        q_full;
  logic        q_empty;
  logic [$bits(lex_item_t)-1:0] q_out;

  // byte to class
  always_comb begin
    case (in_char) inside
      8'h20, [8'h09:8'h0D]: cls = CC_SPACE;
      [8'h30:8'h39]:        cls = CC_DIGIT;
      [8'h41:8'h5A],
      [8'h61:8'h7A]:        cls = CC_ALPHA;
      8'h21:                cls = CC_BANG;    // !
      8'h3D:                cls = CC_EQ;      // =
      8'h3C:                cls = CC_LT;      // <
      8'h3E:                cls = CC_GT;      // >
      8'h26:                cls = CC_AMP;     // &
      8'h7C:                cls = CC_PIPE;    // |
      8'h2B:                cls = CC_PLUS;
      8'h2D:                cls = CC_MINUS;
      8'h2A:                cls = CC_STAR;
      8'h2F:                cls = CC_SLASH;
      8'h25:                cls = CC_PCT;
      8'h7B:                cls = CC_LBRACE;
      8'h7D:                cls = CC_RBRACE;
      8'h28:                cls = CC_LPAREN;
      8'h29:                cls = CC_RPAREN;
      8'h3B:                cls = CC_SEMI;
      default:              cls = CC_BAD;
    endcase
  end

  always_comb begin
    item_in.end_mark = in_end;
    item_in.is_zero  = (in_char == 8'h30);
    item_in.cls      = cls;
  end

  assign in_ready   = !q_full;
  assign item_valid = !q_empty;
  assign item       = lex_item_t'(q_out);

  // queue towards the engine
  sll_fifo #(
    .WIDTH ($bits(lex_item_t)),
    .DEPTH (DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (in_valid),
    .push_data (item_in),
    .full      (q_full),
    .pop       (item_pop),
    .pop_data  (q_out),
    .empty     (q_empty)
  );

endmodule

[rtl/core/sll_back.sv]
// ----------------------------------------------------------------------------
// sll_back - lexing engine and result queue
// Tracks the pending token, forms up to two results per item, queues them.
// ----------------------------------------------------------------------------
module sll_back
  import sll_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic      clk,
  input  logic      rst,
  input  logic      item_valid,
  input  lex_item_t item,
  output logic      item_pop,
  output logic      res_valid,
  input  logic      res_ready,
  output result_t   res
);

  localparam int WIDE  = (POSITION_BITS > 16) ? POSITION_BITS : 16;
  localparam int CAP16 = 65535;

  typedef enum logic [7:0] {
    M_IDLE  = 8'b0000_0001,
    M_INT   = 8'b0000_0010,
    M_NAME  = 8'b0000_0100,
    M_BANG  = 8'b0000_1000,
    M_EQ    = 8'b0001_0000,
    M_REL   = 8'b0010_0000,
    M_LOGIC = 8'b0100_0000,
    M_ERR   = 8'b1000_0000
  } mode_t;

  // state
  mode_t                    mode, mode_next;
  logic [POSITION_BITS-1:0] pos, pos_next;
  logic [POSITION_BITS-1:0] tstart, tstart_next;
  char_class_t              pclass, pclass_next;
  logic                     pzero, pzero_next;
  logic                     lzero, lzero_next;
  logic                     has_letter, has_letter_next;
  logic                     phase;

  // result forming
  result_t     res_a, res_b, r0, r1, push_res;
  logic        have_a, have_b, two, any, taken, alnum;
  logic [15:0] start_cap, len_cap, pos_cap;
  logic        push, rq_full, rq_empty;
  logic [$bits(result_t)-1:0] rq_out;

  function automatic logic [15:0] cap16(input logic [POSITION_BITS-1:0] v);
    logic [WIDE-1:0] ext;
    ext   = WIDE'(v);
    cap16 = (ext > WIDE'(CAP16)) ? 16'hFFFF : ext[15:0];
  endfunction

  function automatic result_t mk(input logic [3:0] kind, input logic [3:0] op,
                                 input logic lor, input logic [15:0] start,
                                 input logic [15:0] len, input logic [1:0] err);
    result_t r;
    r.kind  = kind;
    r.op    = op;
    r.lor   = lor;
    r.start = start;
    r.len   = len;
    r.err   = err;
    r.last  = 1'b0;
    mk      = r;
  endfunction

  assign start_cap = cap16(tstart);
  assign len_cap   = cap16(pos - tstart);
  assign pos_cap   = cap16(pos);
  assign alnum     = (item.cls == CC_DIGIT) || (item.cls == CC_ALPHA);

  // next state and results for the item at the queue head
  always_comb begin
    mode_next       = mode;
    pos_next        = pos;
    tstart_next     = tstart;
    pclass_next     = pclass;
    pzero_next      = pzero;
    lzero_next      = lzero;
    has_letter_next = has_letter;
    res_a           = '0;
    res_b           = '0;
    have_a          = 1'b0;
    have_b          = 1'b0;
    taken           = 1'b0;

    if (item.end_mark) begin
      // flush the pending token, then end-of-file; back to reset values
      have_a = 1'b1;
      case (mode)
        M_INT: begin
          if (has_letter || lzero) begin
            res_a = mk(KIND_ERROR, OP_NONE, 1'b0, start_cap, len_cap, ERR_INT);
          end else begin
            res_a = mk(KIND_INT, OP_NONE, 1'b0, start_cap, len_cap, ERR_NONE);
          end
        end
        M_NAME:  res_a = mk(KIND_NAME, OP_NONE, 1'b0, start_cap, len_cap, ERR_NONE);
        M_BANG:  res_a = mk(KIND_NOT, OP_NONE, 1'b0, start_cap, 16'd1, ERR_NONE);
        M_EQ:    res_a = mk(KIND_ASSIGN, OP_NONE, 1'b0, start_cap, 16'd1, ERR_NONE);
        M_REL: begin
          res_a = mk(KIND_REL, (pclass == CC_LT) ? OP_LT : OP_GT, 1'b0,
                     start_cap, 16'd1, ERR_NONE);
        end
        M_LOGIC: res_a = mk(KIND_ERROR, OP_NONE, 1'b0, start_cap, 16'd1, ERR_LOGIC);
        default: have_a = 1'b0;
      endcase
      have_b          = 1'b1;
      res_b           = mk(KIND_EOF, OP_NONE, 1'b0, pos_cap, 16'd0, ERR_NONE);
      mode_next       = M_IDLE;
      pos_next        = '0;
      tstart_next     = '0;
      lzero_next      = 1'b0;
      has_letter_next = 1'b0;
    end else begin
      // close or extend the pending token
      case (mode)
        M_INT: begin
          if (alnum) begin
            taken = 1'b1;
            if (item.cls == CC_ALPHA) has_letter_next = 1'b1;
            if (pzero) lzero_next = 1'b1;
          end else if (has_letter || lzero) begin
            have_a    = 1'b1;
            res_a     = mk(KIND_ERROR, OP_NONE, 1'b0, start_cap, len_cap, ERR_INT);
            mode_next = M_ERR;
            taken     = 1'b1;
          end else begin
            have_a    = 1'b1;
            res_a     = mk(KIND_INT, OP_NONE, 1'b0, start_cap, len_cap, ERR_NONE);
            mode_next = M_IDLE;
          end
        end
        M_NAME: begin
          if (alnum) begin
            taken = 1'b1;
          end else begin
            have_a    = 1'b1;
            res_a     = mk(KIND_NAME, OP_NONE, 1'b0, start_cap, len_cap, ERR_NONE);
            mode_next = M_IDLE;
          end
        end
        M_BANG, M_EQ: begin
          have_a = 1'b1;
          if (item.cls == CC_EQ) begin
            res_a = mk(KIND_REL, (mode == M_BANG) ? OP_NE : OP_EQEQ, 1'b0,
                       start_cap, 16'd2, ERR_NONE);
            taken = 1'b1;
          end else begin
            res_a = mk((mode == M_BANG) ? KIND_NOT : KIND_ASSIGN, OP_NONE, 1'b0,
                       start_cap, 16'd1, ERR_NONE);
          end
          mode_next = M_IDLE;
        end
        M_REL: begin
          have_a = 1'b1;
          if (item.cls == CC_EQ) begin
            res_a = mk(KIND_REL, (pclass == CC_LT) ? OP_LE : OP_GE, 1'b0,
                       start_cap, 16'd2, ERR_NONE);
            taken = 1'b1;
          end else begin
            res_a = mk(KIND_REL, (pclass == CC_LT) ? OP_LT : OP_GT, 1'b0,
                       start_cap, 16'd1, ERR_NONE);
          end
          mode_next = M_IDLE;
        end
        M_LOGIC: begin
          taken  = 1'b1;
          have_a = 1'b1;
          if (item.cls == pclass) begin
            res_a = mk(KIND_LOGIC, OP_LOGIC, (pclass == CC_PIPE), start_cap, 16'd2,
                       ERR_NONE);
            mode_next = M_IDLE;
          end else begin
            res_a     = mk(KIND_ERROR, OP_NONE, 1'b0, start_cap, 16'd2, ERR_LOGIC);
            mode_next = M_ERR;
          end
        end
        M_ERR:   taken = 1'b1;
        default: mode_next = M_IDLE;
      endcase

      // start a new token from idle
      if (!taken) begin
        mode_next = M_IDLE;
        if (item.cls != CC_SPACE) begin
          tstart_next     = pos;
          pclass_next     = item.cls;
          pzero_next      = item.is_zero;
          lzero_next      = 1'b0;
          has_letter_next = 1'b0;
          have_b          = 1'b1;
          case (item.cls)
            CC_DIGIT: begin
              have_b    = 1'b0;
              mode_next = M_INT;
            end
            CC_ALPHA: begin
              have_b    = 1'b0;
              mode_next = M_NAME;
            end
            CC_BANG: begin
              have_b    = 1'b0;
              mode_next = M_BANG;
            end
            CC_EQ: begin
              have_b    = 1'b0;
              mode_next = M_EQ;
            end
            CC_LT, CC_GT: begin
              have_b    = 1'b0;
              mode_next = M_REL;
            end
            CC_AMP, CC_PIPE: begin
              have_b    = 1'b0;
              mode_next = M_LOGIC;
            end
            CC_PLUS:   res_b = mk(KIND_ADD, OP_PLUS, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_MINUS:  res_b = mk(KIND_ADD, OP_MINUS, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_STAR:   res_b = mk(KIND_MUL, OP_STAR, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_SLASH:  res_b = mk(KIND_MUL, OP_SLASH, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_PCT:    res_b = mk(KIND_MUL, OP_PCT, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_LBRACE: res_b = mk(KIND_LBRACE, OP_NONE, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_RBRACE: res_b = mk(KIND_RBRACE, OP_NONE, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_LPAREN: res_b = mk(KIND_LPAREN, OP_NONE, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_RPAREN: res_b = mk(KIND_RPAREN, OP_NONE, 1'b0, pos_cap, 16'd1, ERR_NONE);
            CC_SEMI:   res_b = mk(KIND_SEMI, OP_NONE, 1'b0, pos_cap, 16'd1, ERR_NONE);
            default: begin
              res_b     = mk(KIND_ERROR, OP_NONE, 1'b0, pos_cap, 16'd1, ERR_CHAR);
              mode_next = M_ERR;
            end
          endcase
        end
      end

      // saturating byte position
      if (pos != '1) begin
        pos_next = pos + POSITION_BITS'(1);
      end
    end
  end

  // result ordering; a second result is written in the second-result phase
  always_comb begin
    r0       = have_a ? res_a : res_b;
    r1       = res_b;
    two      = have_a && have_b;
    any      = have_a || have_b;
    push_res = phase ? r1 : r0;
    push_res.last = !two || phase;
  end

  assign push     = item_valid && any && !rq_full;
  assign item_pop = item_valid && (!any || (!rq_full && (!two || phase)));

  // engine state, updated once the item is fully handled
  always_ff @(posedge clk) begin
    if (rst) begin
      mode       <= M_IDLE;
      pos        <= '0;
      tstart     <= '0;
      lzero      <= 1'b0;
      has_letter <= 1'b0;
      phase      <= 1'b0;
    end else begin
      if (item_pop) begin
        mode       <= mode_next;
        pos        <= pos_next;
        tstart     <= tstart_next;
        lzero      <= lzero_next;
        has_letter <= has_letter_next;
        phase      <= 1'b0;
      end else if (push && two) begin
        phase <= 1'b1;
      end
    end
  end

  // pending byte's class, payload only
  always_ff @(posedge clk) begin
    if (item_pop) begin
      pclass <= pclass_next;
      pzero  <= pzero_next;
    end
  end

  sll_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (2)
  ) u_results (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_data (push_res),
    .full      (rq_full),
    .pop       (res_ready),
    .pop_data  (rq_out),
    .empty     (rq_empty)
  );

  assign res_valid = !rq_empty;
  assign res       = result_t'(rq_out);

  // second-result phase only while a two-result item waits at the head
  a_phase_two: assert property (@(posedge clk) disable iff (rst)
    phase |-> (item_valid && two))
    else $error("second-result phase without a two-result item");

  // end of input returns the position to zero
  a_end_clears: assert property (@(posedge clk) disable iff (rst)
    (item_pop && item.end_mark) |=> (pos == '0 && mode == M_IDLE))
    else $error("end marker did not reset the engine");

  // error mode holds until the end marker
  a_err_sticky: assert property (@(posedge clk) disable iff (rst)
    (mode == M_ERR && item_pop && !item.end_mark) |=> (mode == M_ERR))
    else $error("left error mode before end of input");

  // the final result of an item is written in the cycle the item retires
  a_last_pops: assert property (@(posedge clk) disable iff (rst)
    (push && push_res.last) |-> item_pop)
    else $error("final result queued without retiring its item");

endmodule

[rtl/core/statement_language_lexer.sv]
// ----------------------------------------------------------------------------
// statement_language_lexer - streaming lexer for a small statement language
// Source bytes in, tokens (kind, operator, start, length, error) out.
//
//  channel  dir  tdata                                  tuser        tlast
//  s_axis   in   [7:0] character                        -            end marker
//  m_axis   out  [3:0] op, [4] or, [20:5] start,        [3:0] kind   last result
//                [36:21] length, [38:37] error                       of its byte
//
// One byte per cycle is accepted while the input queue has room; a byte that yields
// two results holds the engine until both are written, as the result queue takes one
// write a cycle. Bytes are registered in the input queue, results in the result queue.
// Reset is synchronous; it clears queues and returns the lexer to idle.
// Either side may stall; the two queues let intake and output wait apart.
// ----------------------------------------------------------------------------
module statement_language_lexer
  import sll_pkg::*;
#(
  parameter int POSITION_BITS = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // [7:0] character
  input  logic        s_axis_tlast,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [39:0] m_axis_tdata,   // operator_code, logical_is_or, start_position,
                                      // token_length, error_code, zero pad
  output logic [3:0]  m_axis_tuser,   // token_kind
  output logic        m_axis_tlast
);

  logic      item_valid;
  logic      item_pop;
  lex_item_t item;
  result_t   res;

  // classification and intake queue
  sll_front #(
    .DEPTH (2)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (s_axis_tvalid),
    .in_ready   (s_axis_tready),
    .in_char    (s_axis_tdata),
    .in_end     (s_axis_tlast),
    .item_valid (item_valid),
    .item_pop   (item_pop),
    .item       (item)
  );

  // lexing engine and result queue
  sll_back #(
    .POSITION_BITS (POSITION_BITS)
  ) u_back (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item       (item),
    .item_pop   (item_pop),
    .res_valid  (m_axis_tvalid),
    .res_ready  (m_axis_tready),
    .res        (res)
  );

  // output packing
  assign m_axis_tdata = {1'b0, res.err, res.len, res.start, res.lor, res.op};
  assign m_axis_tuser = res.kind;
  assign m_axis_tlast = res.last;

endmodule
